// ===== hdl/adtt_pkg.sv =====
// ----------------------------------------------------------------------------
// adtt_pkg
// Types and constants shared by the audio dynamics trend tracker.
// ----------------------------------------------------------------------------
package adtt_pkg;

    localparam int LEVEL_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int MUL_W      = 17;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;
    localparam logic [6:0]         FLOOR_RISE = 7'd66;

    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LENGTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_FACTOR = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TREND_THRESHOLD  = 8'd3;

    localparam logic [7:0]  RST_HISTORY_LENGTH   = 8'd86;
    localparam logic [15:0] RST_PEAK_DECAY       = 16'd64880;
    localparam logic [15:0] RST_SMOOTHING_FACTOR = 16'd58982;
    localparam logic [15:0] RST_TREND_THRESHOLD  = 16'd4915;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PEAK_MUL,
        ST_WALK,
        ST_DRAIN,
        ST_SUMS,
        ST_AVG_DIV,
        ST_MUL_NH,
        ST_MUL_ON,
        ST_TREND_DIV,
        ST_MIX_A,
        ST_MIX_B,
        ST_RATIO_DIV,
        ST_EMIT
    } state_t;

endpackage

// ===== hdl/audio_dynamics_trend_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// audio_dynamics_trend_tracker_unit
// Per-frame level tracker: decaying peak, slow floor, history average,
// smoothed trend with crescendo/diminuendo flags and compression ratio.
// ----------------------------------------------------------------------------
// s_valid/s_ready carry one frame RMS level (Q1.15) per beat; m_valid/m_ready
// carry one result beat per input beat, in order. cfg_wr_en/cfg_index/
// cfg_wr_data write a register at the clock edge; the user must write only
// while the unit is idle, which the unit does not enforce; writing
// history_length empties the history ring. With n levels held, the unit walks
// the ring (one memory read a cycle), then does up to five shift-add
// multiplies (peak decay, two trend products, two smoothing terms) and three
// restoring divisions. One item is processed at a time, so a new beat is
// taken only once the unit is back in idle.
// The result waits in an output register: the next beat is accepted while it
// waits, but that beat's result is held back until m_ready frees it.
// Reset (aresetn low, synchronous) restores register defaults, empties the
// ring, clears peak, trend and flags and sets the floor to 1.0.
// ----------------------------------------------------------------------------
module audio_dynamics_trend_tracker_unit #(
    parameter int HISTORY_DEPTH     = 128,
    parameter int MIN_TREND_ENTRIES = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [adtt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [adtt_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [adtt_pkg::LEVEL_W-1:0]        s_rms_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [adtt_pkg::LEVEL_W-1:0] m_trend,
    output logic [adtt_pkg::LEVEL_W-1:0]        m_compression_ratio,
    output logic [adtt_pkg::LEVEL_W-1:0]        m_average_level,
    output logic [adtt_pkg::LEVEL_W-1:0]        m_peak_level,
    output logic [adtt_pkg::LEVEL_W-1:0]        m_floor_level,
    output logic                                m_rising_now,
    output logic                                m_falling_now,
    output logic                                m_rise_started,
    output logic                                m_fall_started
);
    import adtt_pkg::*;

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int LW   = (CW > 8) ? CW : 8;
    localparam int SW   = LEVEL_W + AW;
    localparam int PW   = SW + CW;
    localparam int DVW  = PW + 18;
    localparam int ACCW = SW + 1 + MUL_W;
    localparam int DCW  = $clog2(DVW + 1);
    localparam int RW   = 31;

    state_t state_reg, state_next;

    logic [7:0]  hist_len_reg;
    logic [15:0] peak_decay_reg;
    logic [15:0] smooth_reg;
    logic [15:0] thr_reg;

    logic [LEVEL_W-1:0] ring_mem [HISTORY_DEPTH];
    logic [LEVEL_W-1:0] rd_data_reg;
    logic               pend_reg;
    logic               pend_old_reg;

    logic [CW-1:0]      cnt_reg;
    logic [AW-1:0]      pos_reg;
    logic [AW-1:0]      idx_reg;
    logic [CW-1:0]      wi_reg;
    logic [SW-1:0]      old_sum_reg;
    logic [SW-1:0]      new_sum_reg;

    logic [LEVEL_W-1:0] peak_reg;
    logic [LEVEL_W-1:0] floor_reg;
    logic signed [15:0] smoothed_reg;
    logic signed [15:0] raw_reg;
    logic [15:0]        avg_reg;
    logic [15:0]        ratio_reg;
    logic [PW-1:0]      pa_reg;
    logic               rise_flag_reg;
    logic               fall_flag_reg;

    logic signed [ACCW-1:0] mcand_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic [MUL_W-1:0]       mplr_reg;
    logic [4:0]             mcnt_reg;

    logic [DVW-1:0] dvd_reg;
    logic [PW-1:0]  dsr_reg;
    logic [PW-1:0]  rem_reg;
    logic [DCW-1:0] dcnt_reg;

    logic                   m_valid_reg;
    logic signed [15:0]     m_trend_reg;
    logic [15:0]            m_ratio_reg;
    logic [15:0]            m_avg_reg;
    logic [15:0]            m_peak_reg;
    logic [15:0]            m_floor_reg;
    logic                   m_rise_reg;
    logic                   m_fall_reg;
    logic                   m_rise_st_reg;
    logic                   m_fall_st_reg;

    // control
    logic                   mul_start, mul_clr;
    logic signed [ACCW-1:0] mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic                   div_start;
    logic [DCW-1:0]         div_n;
    logic [DVW-1:0]         div_dvd;
    logic [PW-1:0]          div_dsr;
    logic                   emit;

    // combinational helpers
    logic [LEVEL_W-1:0] lvl_sat;
    logic [LW-1:0]      hl_ext;
    logic [CW-1:0]      eff_len;
    logic [CW-1:0]      cnt_new;
    logic [CW-1:0]      pos_inc;
    logic [AW-1:0]      pos_new;
    logic [AW-1:0]      oldest;
    logic [LEVEL_W-1:0] floor_delta;
    logic [22:0]        floor_prod;
    logic [LEVEL_W-1:0] floor_new;
    logic [CW-1:0]      half;
    logic [CW-1:0]      newer;
    logic [SW-1:0]      sum_total;
    logic               trend_skip;
    logic [PW-1:0]      pb;
    logic               neg;
    logic [PW-1:0]      num;
    logic [PW+2:0]      num5;
    logic [PW:0]        trial;
    logic               qbit;
    logic signed [15:0] raw_clamp;
    logic signed [17:0] st_ext;
    logic signed [17:0] thr_ext;
    logic               rise_now;
    logic               fall_now;
    logic               accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    assign lvl_sat = (s_rms_level > LEVEL_ONE) ? LEVEL_ONE : s_rms_level;
    assign hl_ext  = LW'(hist_len_reg);

    always_comb begin
        if (hist_len_reg == 8'd0) begin
            eff_len = CW'(1);
        end else if (hl_ext > LW'(HISTORY_DEPTH)) begin
            eff_len = CW'(HISTORY_DEPTH);
        end else begin
            eff_len = CW'(hist_len_reg);
        end
    end

    assign cnt_new = (cnt_reg < eff_len) ? cnt_reg + CW'(1) : cnt_reg;
    assign pos_inc = CW'(pos_reg) + CW'(1);
    assign pos_new = (pos_inc >= eff_len) ? '0 : AW'(pos_inc);
    assign oldest  = (cnt_new < eff_len) ? '0 : pos_new;

    assign floor_delta = lvl_sat - floor_reg;
    assign floor_prod  = (23'(floor_delta) << 6) + (23'(floor_delta) << 1);
    assign floor_new   = (lvl_sat < floor_reg) ? lvl_sat
                       : floor_reg + LEVEL_W'(floor_prod[22:16]);

    assign half       = cnt_reg >> 1;
    assign newer      = cnt_reg - half;
    assign sum_total  = old_sum_reg + new_sum_reg;
    assign trend_skip = (32'(cnt_reg) < MIN_TREND_ENTRIES) || (old_sum_reg == '0);

    assign pb   = acc_reg[PW-1:0];
    assign neg  = pa_reg < pb;
    assign num  = neg ? (pb - pa_reg) : (pa_reg - pb);
    assign num5 = ((PW+3)'(num) << 2) + (PW+3)'(num);

    assign trial = {rem_reg, dvd_reg[DVW-1]};
    assign qbit  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        if (neg) begin
            if (dvd_reg > DVW'(32768)) begin
                raw_clamp = 16'sh8000;
            end else begin
                raw_clamp = 16'(16'd0 - dvd_reg[15:0]);
            end
        end else if (dvd_reg > DVW'(32767)) begin
            raw_clamp = 16'sh7FFF;
        end else begin
            raw_clamp = 16'(dvd_reg[15:0]);
        end
    end

    assign st_ext   = 18'(smoothed_reg);
    assign thr_ext  = $signed({2'b00, thr_reg});
    assign rise_now = st_ext > thr_ext;
    assign fall_now = st_ext < -thr_ext;

    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_clr    = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_n      = '0;
        div_dvd    = '0;
        div_dsr    = '0;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (lvl_sat > peak_reg) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_PEAK_MUL;
                        mul_start  = 1'b1;
                        mul_clr    = 1'b1;
                        mul_a      = ACCW'(peak_reg);
                        mul_b      = MUL_W'(peak_decay_reg);
                    end
                end
            end
            ST_PEAK_MUL: begin
                if (mcnt_reg == 5'd0) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (wi_reg == cnt_reg - CW'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_SUMS;
            end
            ST_SUMS: begin
                state_next = ST_AVG_DIV;
                div_start  = 1'b1;
                div_n      = DCW'(SW);
                div_dvd    = DVW'(sum_total) << (DVW - SW);
                div_dsr    = PW'(cnt_reg);
            end
            ST_AVG_DIV: begin
                if (dcnt_reg == '0) begin
                    mul_start = 1'b1;
                    mul_clr   = 1'b1;
                    if (trend_skip) begin
                        state_next = ST_MIX_A;
                        mul_a      = ACCW'(smoothed_reg);
                        mul_b      = MUL_W'(smooth_reg);
                    end else begin
                        state_next = ST_MUL_NH;
                        mul_a      = ACCW'(new_sum_reg);
                        mul_b      = MUL_W'(half);
                    end
                end
            end
            ST_MUL_NH: begin
                if (mcnt_reg == 5'd0) begin
                    state_next = ST_MUL_ON;
                    mul_start  = 1'b1;
                    mul_clr    = 1'b1;
                    mul_a      = ACCW'(old_sum_reg);
                    mul_b      = MUL_W'(newer);
                end
            end
            ST_MUL_ON: begin
                if (mcnt_reg == 5'd0) begin
                    state_next = ST_TREND_DIV;
                    div_start  = 1'b1;
                    div_n      = DCW'(DVW);
                    div_dvd    = DVW'(num5) << 15;
                    div_dsr    = pb;
                end
            end
            ST_TREND_DIV: begin
                if (dcnt_reg == '0) begin
                    state_next = ST_MIX_A;
                    mul_start  = 1'b1;
                    mul_clr    = 1'b1;
                    mul_a      = ACCW'(smoothed_reg);
                    mul_b      = MUL_W'(smooth_reg);
                end
            end
            ST_MIX_A: begin
                if (mcnt_reg == 5'd0) begin
                    state_next = ST_MIX_B;
                    mul_start  = 1'b1;
                    mul_a      = ACCW'(raw_reg);
                    mul_b      = MUL_W'(65536) - MUL_W'(smooth_reg);
                end
            end
            ST_MIX_B: begin
                if (mcnt_reg == 5'd0) begin
                    if (peak_reg == '0) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_RATIO_DIV;
                        div_start  = 1'b1;
                        div_n      = DCW'(RW);
                        div_dvd    = DVW'({floor_reg, 15'd0}) << (DVW - RW);
                        div_dsr    = PW'(peak_reg);
                    end
                end
            end
            ST_RATIO_DIV: begin
                if (dcnt_reg == '0) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                    emit       = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // history ring
    always_ff @(posedge aclk) begin
        if (accept) begin
            ring_mem[pos_reg] <= lvl_sat;
        end
        rd_data_reg <= ring_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_len_reg   <= RST_HISTORY_LENGTH;
            peak_decay_reg <= RST_PEAK_DECAY;
            smooth_reg     <= RST_SMOOTHING_FACTOR;
            thr_reg        <= RST_TREND_THRESHOLD;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            peak_reg       <= '0;
            floor_reg      <= LEVEL_ONE;
            smoothed_reg   <= '0;
            rise_flag_reg  <= 1'b0;
            fall_flag_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            mcnt_reg       <= '0;
            dcnt_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // accept a level
            if (accept) begin
                if (lvl_sat > peak_reg) begin
                    peak_reg <= lvl_sat;
                end
                floor_reg   <= floor_new;
                cnt_reg     <= cnt_new;
                pos_reg     <= pos_new;
                idx_reg     <= oldest;
                wi_reg      <= '0;
                old_sum_reg <= '0;
                new_sum_reg <= '0;
            end

            // walk the ring, oldest first
            pend_reg     <= (state_reg == ST_WALK);
            pend_old_reg <= (wi_reg < half);
            if (state_reg == ST_WALK) begin
                wi_reg  <= wi_reg + CW'(1);
                idx_reg <= (CW'(idx_reg) + CW'(1) == cnt_reg) ? '0 : idx_reg + AW'(1);
            end
            if (pend_reg) begin
                if (pend_old_reg) begin
                    old_sum_reg <= old_sum_reg + SW'(rd_data_reg);
                end else begin
                    new_sum_reg <= new_sum_reg + SW'(rd_data_reg);
                end
            end

            // shift-add multiplier
            if (mul_start) begin
                mcand_reg <= mul_a;
                mplr_reg  <= mul_b;
                mcnt_reg  <= 5'(MUL_W);
                if (mul_clr) begin
                    acc_reg <= '0;
                end
            end else if (mcnt_reg != 5'd0) begin
                if (mplr_reg[0]) begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg <= mcand_reg <<< 1;
                mplr_reg  <= mplr_reg >> 1;
                mcnt_reg  <= mcnt_reg - 5'd1;
            end

            // restoring divider
            if (div_start) begin
                dvd_reg  <= div_dvd;
                dsr_reg  <= div_dsr;
                rem_reg  <= '0;
                dcnt_reg <= div_n;
            end else if (dcnt_reg != '0) begin
                rem_reg  <= qbit ? PW'(trial - {1'b0, dsr_reg}) : PW'(trial);
                dvd_reg  <= {dvd_reg[DVW-2:0], qbit};
                dcnt_reg <= dcnt_reg - DCW'(1);
            end

            // capture results
            if (state_reg == ST_PEAK_MUL && mcnt_reg == 5'd0) begin
                peak_reg <= acc_reg[31:16];
            end
            if (state_reg == ST_AVG_DIV && dcnt_reg == '0) begin
                avg_reg <= dvd_reg[15:0];
                if (trend_skip) begin
                    raw_reg <= '0;
                end
            end
            if (state_reg == ST_MUL_NH && mcnt_reg == 5'd0) begin
                pa_reg <= acc_reg[PW-1:0];
            end
            if (state_reg == ST_TREND_DIV && dcnt_reg == '0) begin
                raw_reg <= raw_clamp;
            end
            if (state_reg == ST_MIX_B && mcnt_reg == 5'd0) begin
                smoothed_reg <= acc_reg[31:16];
                if (peak_reg == '0) begin
                    ratio_reg <= LEVEL_ONE;
                end
            end
            if (state_reg == ST_RATIO_DIV && dcnt_reg == '0) begin
                ratio_reg <= (dvd_reg > DVW'(LEVEL_ONE)) ? LEVEL_ONE : dvd_reg[15:0];
            end

            // result beat
            if (emit) begin
                m_valid_reg   <= 1'b1;
                m_trend_reg   <= smoothed_reg;
                m_ratio_reg   <= ratio_reg;
                m_avg_reg     <= avg_reg;
                m_peak_reg    <= peak_reg;
                m_floor_reg   <= floor_reg;
                m_rise_reg    <= rise_now;
                m_fall_reg    <= fall_now;
                m_rise_st_reg <= rise_now && !rise_flag_reg;
                m_fall_st_reg <= fall_now && !fall_flag_reg;
                rise_flag_reg <= rise_now;
                fall_flag_reg <= fall_now;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // configuration writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_HISTORY_LENGTH: begin
                        hist_len_reg <= cfg_wr_data[7:0];
                        cnt_reg      <= '0;
                        pos_reg      <= '0;
                    end
                    REG_PEAK_DECAY: begin
                        peak_decay_reg <= cfg_wr_data;
                    end
                    REG_SMOOTHING_FACTOR: begin
                        smooth_reg <= cfg_wr_data;
                    end
                    REG_TREND_THRESHOLD: begin
                        thr_reg <= cfg_wr_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_trend             = m_trend_reg;
    assign m_compression_ratio = m_ratio_reg;
    assign m_average_level     = m_avg_reg;
    assign m_peak_level        = m_peak_reg;
    assign m_floor_level       = m_floor_reg;
    assign m_rising_now        = m_rise_reg;
    assign m_falling_now       = m_fall_reg;
    assign m_rise_started      = m_rise_st_reg;
    assign m_fall_started      = m_fall_st_reg;

endmodule
